/* rtl/tdc_pkg.sv */
package tdc_pkg;

    localparam int NUM_THR = 4;
    localparam int TIME_W  = 32;
    localparam int PM_W    = 10;
    localparam int THR_W   = 3;
    localparam int MASK_W  = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_WINDOW       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_TRAIL_WINDOW = 1'd1;

    localparam logic KIND_LEAD  = 1'b0;
    localparam logic KIND_TRAIL = 1'b1;

    typedef struct packed {
        logic [PM_W-1:0]   pm_id;
        logic [TIME_W-1:0] edge_time;
        logic [THR_W-1:0]  threshold;
        logic              edge_kind;
        logic              batch_last;
    } t_edge;

    typedef struct packed {
        logic [PM_W-1:0]   signal_pm;
        logic [TIME_W-1:0] lead_thr1;
        logic [TIME_W-1:0] lead_thr2;
        logic [TIME_W-1:0] lead_thr3;
        logic [TIME_W-1:0] lead_thr4;
        logic [TIME_W-1:0] trail_thr1;
        logic [TIME_W-1:0] trail_thr2;
        logic [TIME_W-1:0] trail_thr3;
        logic [TIME_W-1:0] trail_thr4;
        logic [MASK_W-1:0] found_mask;
        logic              signal_last;
        logic              overflow;
    } t_signal;

    function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/tdc_if.sv */
interface tdc_edge_if;
    import tdc_pkg::*;
    logic  valid;
    logic  ready;
    t_edge data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tdc_sig_if.sv */
interface tdc_sig_if;
    import tdc_pkg::*;
    logic    valid;
    logic    ready;
    t_signal data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tdc_fifo.sv */
module tdc_fifo
    import tdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_edge i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_edge o_data
);
    // Two-entry queue between the input side and the list loader.
    t_edge      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overrun");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underrun");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
`endif
endmodule

/* rtl/tdc_engine.sv */
module tdc_engine
    import tdc_pkg::*;
#(
    parameter int LIST_DEPTH  = 16,
    parameter int MAX_SIGNALS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TIME_W-1:0] i_edge_window,
    input  logic [TIME_W-1:0] i_lt_window,
    input  logic              i_empty,
    input  t_edge             i_edge,
    output logic              o_pop,
    tdc_sig_if.source         out_if
);
    localparam int IW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FW  = $clog2(LIST_DEPTH + 1);
    localparam int AW  = $clog2(NUM_THR) + IW;
    localparam int SW  = $clog2(MAX_SIGNALS + 1);
    localparam int LIM = (LIST_DEPTH < MAX_SIGNALS) ? LIST_DEPTH : MAX_SIGNALS;
    localparam int TW  = $clog2(NUM_THR);
    // Each list owns a power-of-two slot range so {threshold, index} is a valid address.
    localparam int SLOTS = NUM_THR << IW;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SIG   = 3'd1;
    localparam logic [2:0] ST_RDLD  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // Lists live in two memories, one read per cycle each.
    logic [TIME_W-1:0] r_lead_mem  [SLOTS];
    logic [TIME_W-1:0] r_trail_mem [SLOTS];
    logic [SLOTS-1:0] r_lead_used, r_trail_used;
    logic [FW-1:0] r_lfill [NUM_THR];
    logic [FW-1:0] r_tfill [NUM_THR];
    logic [PM_W-1:0] r_pm;
    logic            r_drop;

    logic [2:0]      r_st;
    logic [SW-1:0]   r_sig, r_nsig;
    logic [TIME_W-1:0] r_ref;
    logic [TW-1:0]   r_thr;
    logic            r_trail;       // scanning trailing list of r_thr
    logic [FW-1:0]   r_idx;         // entry being addressed
    logic            r_rvalid;
    logic [TIME_W-1:0] r_lrd, r_trd;
    logic [TIME_W-1:0] r_lead [NUM_THR];
    logic [TIME_W-1:0] r_trl  [NUM_THR];
    logic [MASK_W-1:0] r_mask;
    logic            r_ovalid;
    t_signal         r_out;

    t_edge e;
    logic  in_rng;
    logic [TW-1:0] e_lst;
    assign e      = i_edge;
    assign in_rng = (e.threshold >= 3'd1) && (e.threshold <= 3'(NUM_THR));
    assign e_lst  = TW'(e.threshold - 3'd1);

    assign o_pop = (r_st == ST_LOAD) && !i_empty;
    assign out_if.valid = r_ovalid;
    assign out_if.data  = r_out;

    logic [FW-1:0] cur_fill;
    logic [AW-1:0] cur_addr, r_raddr;
    logic [TIME_W-1:0] cur_rd;
    logic cur_used, cur_hit, at_end;
    assign cur_fill = r_trail ? r_tfill[r_thr] : r_lfill[r_thr];
    assign cur_addr = {r_thr, r_idx[IW-1:0]};
    assign cur_rd   = r_trail ? r_trd : r_lrd;
    assign cur_used = r_trail ? r_trail_used[r_raddr] : r_lead_used[r_raddr];
    assign cur_hit  = r_rvalid && !cur_used &&
        (abs_diff(r_ref, cur_rd) < (r_trail ? i_lt_window : i_edge_window));
    assign at_end   = (r_idx >= cur_fill);

    always_ff @(posedge i_clk) begin
        r_lrd <= r_lead_mem[r_st == ST_SIG ? AW'(r_sig) : cur_addr];
        r_trd <= r_trail_mem[cur_addr];
        if (o_pop && in_rng) begin
            if (e.edge_kind == KIND_TRAIL) begin
                if (r_tfill[e_lst] < FW'(LIST_DEPTH))
                    r_trail_mem[{e_lst, r_tfill[e_lst][IW-1:0]}] <= e.edge_time;
            end else if (r_lfill[e_lst] < FW'(LIST_DEPTH)) begin
                r_lead_mem[{e_lst, r_lfill[e_lst][IW-1:0]}] <= e.edge_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_LOAD;
            r_lead_used <= '0;
            r_trail_used <= '0;
            for (int k = 0; k < NUM_THR; k++) begin
                r_lfill[k] <= '0;
                r_tfill[k] <= '0;
            end
            r_pm <= '0;
            r_drop <= 1'b0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            // The emit state reloads the output register itself.
            if (out_if.valid && out_if.ready && r_st != ST_EMIT) r_ovalid <= 1'b0;
            unique case (r_st)
                ST_LOAD: if (o_pop) begin
                    r_pm <= e.pm_id;
                    if (in_rng) begin
                        if (e.edge_kind == KIND_TRAIL) begin
                            if (r_tfill[e_lst] < FW'(LIST_DEPTH)) begin
                                r_trail_used[{e_lst, r_tfill[e_lst][IW-1:0]}] <= 1'b0;
                                r_tfill[e_lst] <= r_tfill[e_lst] + 1'b1;
                            end else r_drop <= 1'b1;
                        end else begin
                            if (r_lfill[e_lst] < FW'(LIST_DEPTH)) begin
                                r_lead_used[{e_lst, r_lfill[e_lst][IW-1:0]}] <= 1'b0;
                                r_lfill[e_lst] <= r_lfill[e_lst] + 1'b1;
                            end else r_drop <= 1'b1;
                        end
                    end
                    if (e.batch_last) begin
                        r_sig <= '0;
                        r_st  <= ST_SIG;
                    end
                end
                ST_SIG: begin
                    // Limit taken after the last edge has been loaded.
                    r_nsig <= (r_lfill[0] > FW'(LIM)) ? SW'(LIM) : SW'(r_lfill[0]);
                    if (r_sig >= ((r_lfill[0] > FW'(LIM)) ? SW'(LIM) : SW'(r_lfill[0])))
                    begin
                        r_lead_used <= '0;
                        r_trail_used <= '0;
                        for (int k = 0; k < NUM_THR; k++) begin
                            r_lfill[k] <= '0;
                            r_tfill[k] <= '0;
                        end
                        r_drop <= 1'b0;
                        r_st <= ST_LOAD;
                    end else begin
                        r_lead_used[AW'(r_sig)] <= 1'b1;
                        r_st <= ST_RDLD;
                    end
                end
                ST_RDLD: begin
                    r_ref <= r_lrd;
                    for (int k = 0; k < NUM_THR; k++) begin
                        r_lead[k] <= (k == 0) ? r_lrd : '0;
                        r_trl[k]  <= '0;
                    end
                    r_mask <= MASK_W'(1);
                    r_thr <= '0;
                    r_trail <= 1'b1;
                    r_idx <= '0;
                    r_rvalid <= 1'b0;
                    r_st <= ST_SCAN;
                end
                ST_SCAN: begin
                    // One entry issued per cycle, result checked next cycle.
                    r_raddr <= cur_addr;
                    if (cur_hit || at_end) begin
                        logic adv;
                        adv = 1'b1;
                        if (cur_hit) begin
                            if (r_trail) begin
                                r_trail_used[r_raddr] <= 1'b1;
                                r_trl[r_thr] <= r_trd;
                                r_mask[NUM_THR + int'(r_thr)] <= 1'b1;
                            end else begin
                                r_lead_used[r_raddr] <= 1'b1;
                                r_lead[r_thr] <= r_lrd;
                                r_mask[r_thr] <= 1'b1;
                                r_trail <= 1'b1;
                                r_idx <= '0;
                                r_rvalid <= 1'b0;
                                adv = 1'b0;
                            end
                        end
                        if (adv) begin
                            r_rvalid <= 1'b0;
                            r_idx <= '0;
                            r_trail <= 1'b0;
                            if (r_thr == TW'(NUM_THR - 1)) r_st <= ST_EMIT;
                            else r_thr <= r_thr + 1'b1;
                        end
                    end else begin
                        r_rvalid <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_EMIT: if (!r_ovalid || out_if.ready) begin
                    r_ovalid <= 1'b1;
                    r_out.signal_pm  <= r_pm;
                    r_out.lead_thr1  <= r_lead[0];
                    r_out.lead_thr2  <= r_lead[1];
                    r_out.lead_thr3  <= r_lead[2];
                    r_out.lead_thr4  <= r_lead[3];
                    r_out.trail_thr1 <= r_trl[0];
                    r_out.trail_thr2 <= r_trl[1];
                    r_out.trail_thr3 <= r_trl[2];
                    r_out.trail_thr4 <= r_trl[3];
                    r_out.found_mask <= r_mask;
                    r_out.signal_last <= (r_sig + 1'b1 == r_nsig);
                    r_out.overflow   <= r_drop;
                    r_sig <= r_sig + 1'b1;
                    r_st <= ST_SIG;
                end
                default: r_st <= ST_LOAD;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_pop_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_st == ST_LOAD) else $error("pop outside load");
    a_mask_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_out.found_mask[0]) else $error("lead bit missing");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfill[0] <= FW'(LIST_DEPTH)) else $error("fill above depth");
`endif
endmodule

/* rtl/tdc_edge_signal_assembler.sv */
// Edge signal assembler for one photomultiplier.
// in_if carries edge words (pm id, time, threshold, kind, batch-last flag);
// out_if carries one assembled signal word per threshold-1 leading edge,
// at most MAX_SIGNALS per batch. Windows are written through the plain
// register port (index 0 edge window, 1 lead-trail window), by the user
// only while idle; the block does not enforce this. Edges load at one per
// cycle, outside assembly, into per-threshold lists from a registered
// two-word queue. The batch-last word starts assembly: each signal passes
// a setup state and a reference read state, then searches four to seven
// lists (threshold-1 trailing, leading on thresholds 2 to 4, and the
// trailing list of every threshold whose leading edge was found), then
// emits. At the end of a batch the lists are emptied and loading resumes.
// No new edges are loaded during assembly; the queue absorbs two words.
// If the receiver stalls, the output register holds its word and
// assembly waits before the next emit. Reset clears fill counts, used and
// drop flags and windows; list contents are undefined until written.
module tdc_edge_signal_assembler
    import tdc_pkg::*;
#(
    parameter int LIST_DEPTH  = 16,
    parameter int MAX_SIGNALS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_data,
    tdc_edge_if.sink             in_if,
    tdc_sig_if.source            out_if
);
    logic [TIME_W-1:0] r_edge_window, r_lt_window;
    logic  full, empty, pop;
    t_edge qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_window <= '0;
            r_lt_window   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EDGE_WINDOW:       r_edge_window <= i_cfg_data;
                REG_LEAD_TRAIL_WINDOW: r_lt_window   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_if.ready = !full;

    tdc_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push (in_if.valid && !full),
        .i_data (in_if.data),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (qd)
    );

    tdc_engine #(.LIST_DEPTH(LIST_DEPTH), .MAX_SIGNALS(MAX_SIGNALS)) u_engine (
        .i_clk, .i_rst_n,
        .i_edge_window(r_edge_window),
        .i_lt_window  (r_lt_window),
        .i_empty      (empty),
        .i_edge       (qd),
        .o_pop        (pop),
        .out_if       (out_if)
    );
endmodule

/* tb/sv/tdc_edge_signal_assembler_test.sv */
`timescale 1ns / 1ps

module tdc_edge_signal_assembler_test;
    import tdc_pkg::*;

    localparam int DEPTH       = 16;
    localparam int MAX_SIG     = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RAND_ITEMS  = 384;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TIME_W-1:0]    i_cfg_data;

    tdc_edge_if edge_ch ();
    tdc_sig_if  sig_ch ();

    tdc_edge_signal_assembler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_if      (edge_ch.sink),
        .out_if     (sig_ch.source)
    );

    // Predictor state.
    logic [TIME_W-1:0] win_edge, win_lt;
    logic [TIME_W-1:0] lead_times [NUM_THR][DEPTH];
    logic [TIME_W-1:0] trail_times[NUM_THR][DEPTH];
    bit                lead_taken [NUM_THR][DEPTH];
    bit                trail_taken[NUM_THR][DEPTH];
    int                lead_cnt [NUM_THR];
    int                trail_cnt[NUM_THR];
    logic [PM_W-1:0]   cur_pm;
    bit                edge_dropped;

    t_signal expected_signals[$];
    int      mismatches;
    int      cycle_count;
    int      words_sent;
    bit      sender_idle_on;
    bit      receiver_idle_on;
    bit      receiver_hold;
    int      hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [TIME_W-1:0] gap(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void clear_batch();
        for (int t = 0; t < NUM_THR; t++) begin
            lead_cnt[t] = 0;
            trail_cnt[t] = 0;
            for (int i = 0; i < DEPTH; i++) begin
                lead_taken[t][i] = 0;
                trail_taken[t][i] = 0;
            end
        end
        edge_dropped = 0;
    endfunction

    // Takes the earliest unused entry within the window; returns its index or -1.
    function automatic int take_trail(int t, logic [TIME_W-1:0] ref_t);
        for (int i = 0; i < trail_cnt[t]; i++)
            if (!trail_taken[t][i] && gap(ref_t, trail_times[t][i]) < win_lt) begin
                trail_taken[t][i] = 1;
                return i;
            end
        return -1;
    endfunction

    function automatic int take_lead(int t, logic [TIME_W-1:0] ref_t);
        for (int i = 0; i < lead_cnt[t]; i++)
            if (!lead_taken[t][i] && gap(ref_t, lead_times[t][i]) < win_edge) begin
                lead_taken[t][i] = 1;
                return i;
            end
        return -1;
    endfunction

    function automatic void predict_signals(t_edge e);
        int t, n, hit;
        t_signal s;
        logic [TIME_W-1:0] lead1;
        logic [TIME_W-1:0] leads[NUM_THR];
        logic [TIME_W-1:0] trails[NUM_THR];
        logic [MASK_W-1:0] mask;
        cur_pm = e.pm_id;
        if (e.threshold >= 1 && e.threshold <= NUM_THR) begin
            t = e.threshold - 1;
            if (e.edge_kind == KIND_TRAIL) begin
                if (trail_cnt[t] >= DEPTH) edge_dropped = 1;
                else begin
                    trail_times[t][trail_cnt[t]] = e.edge_time;
                    trail_taken[t][trail_cnt[t]] = 0;
                    trail_cnt[t]++;
                end
            end else begin
                if (lead_cnt[t] >= DEPTH) edge_dropped = 1;
                else begin
                    lead_times[t][lead_cnt[t]] = e.edge_time;
                    lead_taken[t][lead_cnt[t]] = 0;
                    lead_cnt[t]++;
                end
            end
        end
        if (!e.batch_last) return;
        n = (lead_cnt[0] > MAX_SIG) ? MAX_SIG : lead_cnt[0];
        for (int k = 0; k < n; k++) begin
            lead1 = lead_times[0][k];
            lead_taken[0][k] = 1;
            for (int j = 0; j < NUM_THR; j++) begin
                leads[j] = '0;
                trails[j] = '0;
            end
            leads[0] = lead1;
            mask = 8'h01;
            hit = take_trail(0, lead1);
            if (hit >= 0) begin
                trails[0] = trail_times[0][hit];
                mask[4] = 1'b1;
            end
            for (int j = 1; j < NUM_THR; j++) begin
                hit = take_lead(j, lead1);
                if (hit >= 0) begin
                    leads[j] = lead_times[j][hit];
                    mask[j] = 1'b1;
                    hit = take_trail(j, lead1);
                    if (hit >= 0) begin
                        trails[j] = trail_times[j][hit];
                        mask[4+j] = 1'b1;
                    end
                end
            end
            s.signal_pm   = cur_pm;
            s.lead_thr1   = leads[0];
            s.lead_thr2   = leads[1];
            s.lead_thr3   = leads[2];
            s.lead_thr4   = leads[3];
            s.trail_thr1  = trails[0];
            s.trail_thr2  = trails[1];
            s.trail_thr3  = trails[2];
            s.trail_thr4  = trails[3];
            s.found_mask  = mask;
            s.signal_last = (k + 1 == n);
            s.overflow    = edge_dropped;
            expected_signals = {expected_signals, s};
        end
        clear_batch();
    endfunction

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Checks each accepted signal word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && sig_ch.valid && sig_ch.ready) begin
            t_signal g, w;
            g = sig_ch.data;
            if (expected_signals.size() == 0) begin
                report_mismatch("unexpected signal, lead_thr1", g.lead_thr1, '0);
            end else begin
                w = expected_signals.pop_front();
                if (g.signal_pm !== w.signal_pm)
                    report_mismatch("signal_pm", TIME_W'(g.signal_pm), TIME_W'(w.signal_pm));
                if (g.lead_thr1 !== w.lead_thr1) report_mismatch("lead_thr1", g.lead_thr1, w.lead_thr1);
                if (g.lead_thr2 !== w.lead_thr2) report_mismatch("lead_thr2", g.lead_thr2, w.lead_thr2);
                if (g.lead_thr3 !== w.lead_thr3) report_mismatch("lead_thr3", g.lead_thr3, w.lead_thr3);
                if (g.lead_thr4 !== w.lead_thr4) report_mismatch("lead_thr4", g.lead_thr4, w.lead_thr4);
                if (g.trail_thr1 !== w.trail_thr1)
                    report_mismatch("trail_thr1", g.trail_thr1, w.trail_thr1);
                if (g.trail_thr2 !== w.trail_thr2)
                    report_mismatch("trail_thr2", g.trail_thr2, w.trail_thr2);
                if (g.trail_thr3 !== w.trail_thr3)
                    report_mismatch("trail_thr3", g.trail_thr3, w.trail_thr3);
                if (g.trail_thr4 !== w.trail_thr4)
                    report_mismatch("trail_thr4", g.trail_thr4, w.trail_thr4);
                if (g.found_mask !== w.found_mask)
                    report_mismatch("found_mask", TIME_W'(g.found_mask), TIME_W'(w.found_mask));
                if (g.signal_last !== w.signal_last)
                    report_mismatch("signal_last", TIME_W'(g.signal_last),
                                    TIME_W'(w.signal_last));
                if (g.overflow !== w.overflow)
                    report_mismatch("overflow", TIME_W'(g.overflow), TIME_W'(w.overflow));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sig_ch.ready <= 1'b0;
            hold_cycles <= 0;
        end else if (receiver_hold && hold_cycles < 400) begin
            sig_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            sig_ch.ready <= receiver_idle_on ? ($urandom_range(99) >= 31) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Valid stays high after the accepting edge; the next word or an idle cycle replaces it.
    task automatic send_word(input t_edge e);
        while (sender_idle_on && $urandom_range(99) < 31) begin
            edge_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.data  <= e;
        @(posedge i_clk);
        while (!edge_ch.ready) @(posedge i_clk);
        predict_signals(e);
        words_sent++;
    endtask

    task automatic drain();
        edge_ch.valid <= 1'b0;
        while (expected_signals.size() != 0) @(posedge i_clk);
        // An assembly with no result may still be running.
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_windows(input logic [TIME_W-1:0] ew, input logic [TIME_W-1:0] lt);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_EDGE_WINDOW;
        i_cfg_data <= ew;
        @(posedge i_clk);
        i_cfg_idx  <= REG_LEAD_TRAIL_WINDOW;
        i_cfg_data <= lt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_edge = ew;
        win_lt = lt;
    endtask

    function automatic t_edge make_edge(logic [PM_W-1:0] pm, logic [TIME_W-1:0] tm,
                                        logic [THR_W-1:0] thr, logic kind, logic last);
        t_edge e;
        e.pm_id = pm;
        e.edge_time = tm;
        e.threshold = thr;
        e.edge_kind = kind;
        e.batch_last = last;
        return e;
    endfunction

    typedef struct {
        t_edge   word;
        bit      known;
        t_signal result;
    } t_row;

    t_row stim_rows[$];

    task automatic add_row(input t_edge e);
        t_row r;
        r.word = e;
        r.known = 0;
        stim_rows = {stim_rows, r};
    endtask

    // A cluster of edges, mostly around a base time with some stray times, thresholds and pm ids, ended by batch_last.
    task automatic send_batch(input int signals, input logic [TIME_W-1:0] spread);
        logic [PM_W-1:0] pm;
        logic [TIME_W-1:0] base;
        int n;
        pm = PM_W'($urandom_range(1023));
        n = signals * 4 + int'($urandom_range(6));
        for (int i = 0; i < n; i++) begin
            t_edge e;
            base = $urandom();
            if ($urandom_range(99) < 85) base = 32'h1000_0000 + $urandom_range(spread);
            e = make_edge(pm, base, ($urandom_range(99) < 5) ? THR_W'($urandom_range(7)) :
                          THR_W'($urandom_range(1, 4)), 1'($urandom_range(1)), i == n - 1);
            if ($urandom_range(99) < 10) e.pm_id = PM_W'($urandom_range(1023));
            send_word(e);
        end
    endtask

    initial begin
        t_row r;
        mismatches = 0;
        cycle_count = 0;
        words_sent = 0;
        sender_idle_on = 1;
        receiver_idle_on = 1;
        receiver_hold = 0;
        win_edge = '0;
        win_lt = '0;
        cur_pm = '0;
        clear_batch();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_EDGE_WINDOW;
        i_cfg_data = '0;
        edge_ch.valid = 1'b0;
        edge_ch.data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Windows at zero after reset: a lone leading edge pairs nothing.
        r.word = make_edge(10'h3FF, 32'hFFFF_FFFF, 3'd1, KIND_LEAD, 1'b1);
        r.known = 1;
        r.result = '{signal_pm: 10'h3FF, lead_thr1: 32'hFFFF_FFFF, found_mask: 8'h01,
                     signal_last: 1'b1, default: '0};
        stim_rows = {stim_rows, r};
        add_row(make_edge(10'd0, 32'd0, 3'd0, KIND_LEAD, 1'b0));
        add_row(make_edge(10'd1, 32'd100, 3'd1, KIND_LEAD, 1'b0));
        add_row(make_edge(10'd1, 32'd150, 3'd2, KIND_LEAD, 1'b0));
        add_row(make_edge(10'd1, 32'd160, 3'd2, KIND_TRAIL, 1'b0));
        add_row(make_edge(10'd1, 32'd300, 3'd1, KIND_TRAIL, 1'b0));
        add_row(make_edge(10'd1, 32'd90, 3'd3, KIND_LEAD, 1'b0));
        add_row(make_edge(10'd1, 32'd200, 3'd3, KIND_TRAIL, 1'b0));
        add_row(make_edge(10'd1, 32'd120, 3'd4, KIND_TRAIL, 1'b0));
        add_row(make_edge(10'd1, 32'd7, 3'd7, KIND_TRAIL, 1'b0));
        add_row(make_edge(10'd2, 32'd0, 3'd4, KIND_LEAD, 1'b1));
        add_row(make_edge(10'd5, 32'd0, 3'd2, KIND_TRAIL, 1'b1));
        add_row(make_edge(10'd6, 32'd0, 3'd5, KIND_LEAD, 1'b1));

        for (int i = 0; i < stim_rows.size(); i++) begin
            send_word(stim_rows[i].word);
            if (stim_rows[i].known) begin
                drain();
                write_windows(32'd100, 32'd250);
            end
        end
        drain();

        // Overflow: eighteen threshold-1 leading edges, full lists on both kinds.
        write_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 18; i++)
            send_word(make_edge(10'd9, TIME_W'(i * 3), 3'd1, KIND_LEAD, 1'b0));
        for (int i = 0; i < 17; i++)
            send_word(make_edge(10'd9, TIME_W'(i), 3'd2, KIND_TRAIL, 1'b0));
        send_word(make_edge(10'd9, 32'hFFFF_FFFF, 3'd4, KIND_LEAD, 1'b1));
        drain();

        // Long receiver hold-off while the sender keeps offering words.
        receiver_hold = 1;
        send_batch(6, 32'd2000);
        send_batch(4, 32'd2000);
        edge_ch.valid <= 1'b0;
        while (expected_signals.size() != 0) @(posedge i_clk);
        receiver_hold = 0;
        drain();

        begin
            int goal;
            logic [TIME_W-1:0] ew_set[4];
            logic [TIME_W-1:0] lt_set[4];
            ew_set = '{32'd0, 32'd300, 32'd5000, 32'hFFFF_FFFF};
            lt_set = '{32'd1, 32'd800, 32'hFFFF_FFFF, 32'd0};
            goal = words_sent;
            for (int phase = 0; phase < 4; phase++) begin
                write_windows(ew_set[phase], lt_set[phase]);
                sender_idle_on = (phase != 1);
                receiver_idle_on = (phase != 1);
                goal = goal + RAND_ITEMS / 4;
                while (words_sent < goal)
                    send_batch(int'($urandom_range(1, 3)),
                               (phase == 2) ? 32'hFFFF : 32'd3000);
                // Sender waits here for every pending signal.
                drain();
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // The directed row with a typed-in result is also checked directly against the first signal.
    initial begin
        @(posedge i_rst_n);
        wait (stim_rows.size() != 0);
        @(posedge i_clk iff (sig_ch.valid && sig_ch.ready));
        if (sig_ch.data !== stim_rows[0].result)
            report_mismatch("first signal after reset differs from typed value, lead_thr1",
                            sig_ch.data.lead_thr1, stim_rows[0].result.lead_thr1);
    end

endmodule
